FILE: rtl/core/krt_pkg.sv
// krt_pkg: shared types and constants of the keyed record table.
// Used by the interfaces, the cell, the head compare unit and the top level.
package krt_pkg;

  localparam int unsigned TableEntriesDef = 256;
  localparam int unsigned RegionShiftDef  = 4;

  localparam int unsigned ReqW    = 3;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned KindW   = 2;
  localparam int unsigned RegionW = 28;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned CountW  = 9;

  typedef enum logic [ReqW-1:0] {
    REQ_LOOKUP       = 3'd0,
    REQ_ADD          = 3'd1,
    REQ_REMOVE       = 3'd2,
    REQ_DROP_REGION  = 3'd3,
    REQ_COUNT_ALL    = 3'd4,
    REQ_COUNT_REGION = 3'd5,
    REQ_CLEAR        = 3'd6
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_REJECTED  = 2'd3
  } status_e;

  localparam logic [KindW-1:0] KindNone = '0;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [KindW-1:0]         kind;
  } entry_t;

  // Compare flags of the entry at the head of the chain.
  typedef struct packed {
    logic live;
    logic key_hit;
    logic region_hit;
  } scan_t;

endpackage

FILE: rtl/core/krt_if.sv
// Request and response channel interfaces of the keyed record table.
// Depends on krt_pkg for the field widths.
interface krt_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [krt_pkg::ReqW-1:0]             req_type;
  logic signed [krt_pkg::CoordW-1:0]    cell_x;
  logic signed [krt_pkg::CoordW-1:0]    cell_y;
  logic signed [krt_pkg::CoordW-1:0]    cell_z;
  logic [krt_pkg::KindW-1:0]            new_kind;
  logic signed [krt_pkg::RegionW-1:0]   region_x;
  logic signed [krt_pkg::RegionW-1:0]   region_z;

  modport source (
    output valid, req_type, cell_x, cell_y, cell_z, new_kind, region_x, region_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, cell_x, cell_y, cell_z, new_kind, region_x, region_z,
    output ready
  );
endinterface

interface krt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [krt_pkg::StatusW-1:0]   status;
  logic [krt_pkg::IndexW-1:0]    entry_index;
  logic [krt_pkg::KindW-1:0]     entry_kind;
  logic [krt_pkg::CountW-1:0]    live_count;

  modport source (
    output valid, status, entry_index, entry_kind, live_count,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, entry_kind, live_count,
    output ready
  );
endinterface

FILE: rtl/core/krt_cell.sv
// krt_cell: one table entry of the circulating chain.
// Depends on krt_pkg for the entry type.
module krt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic            clear_i,
  input  krt_pkg::entry_t entry_i,
  output krt_pkg::entry_t entry_o
);

  logic [krt_pkg::KindW-1:0]         kind_q;
  logic signed [krt_pkg::CoordW-1:0] x_q, y_q, z_q;

  // Kind carries the free/live state and is cleared by reset or clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= krt_pkg::KindNone;
    end else if (clear_i) begin
      kind_q <= krt_pkg::KindNone;
    end else if (shift_i) begin
      kind_q <= entry_i.kind;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      x_q <= entry_i.x;
      y_q <= entry_i.y;
      z_q <= entry_i.z;
    end
  end

  assign entry_o = '{x: x_q, y: y_q, z: z_q, kind: kind_q};

endmodule

FILE: rtl/core/krt_head.sv
// krt_head: key and region compare on the entry leaving the head of the chain.
// Depends on krt_pkg for the entry and flag types.
module krt_head #(
  parameter int unsigned RegionShift = krt_pkg::RegionShiftDef
) (
  input  krt_pkg::entry_t                   entry_i,
  input  logic signed [krt_pkg::CoordW-1:0] key_x_i,
  input  logic signed [krt_pkg::CoordW-1:0] key_y_i,
  input  logic signed [krt_pkg::CoordW-1:0] key_z_i,
  input  logic signed [krt_pkg::RegionW-1:0] region_x_i,
  input  logic signed [krt_pkg::RegionW-1:0] region_z_i,
  output krt_pkg::scan_t                    flags_o
);

  localparam int unsigned ExtW = krt_pkg::CoordW - krt_pkg::RegionW;

  logic signed [krt_pkg::CoordW-1:0] ent_rx, ent_rz, req_rx, req_rz;

  assign ent_rx = $signed(entry_i.x) >>> RegionShift;
  assign ent_rz = $signed(entry_i.z) >>> RegionShift;
  assign req_rx = {{ExtW{region_x_i[krt_pkg::RegionW-1]}}, region_x_i};
  assign req_rz = {{ExtW{region_z_i[krt_pkg::RegionW-1]}}, region_z_i};

  always_comb begin
    flags_o.live       = (entry_i.kind != krt_pkg::KindNone);
    flags_o.key_hit    = flags_o.live && (entry_i.x == key_x_i) &&
                         (entry_i.y == key_y_i) && (entry_i.z == key_z_i);
    flags_o.region_hit = flags_o.live && (ent_rx == req_rx) && (ent_rz == req_rz);
  end

endmodule

FILE: rtl/core/keyed_record_table.sv
// Keyed record table: TableEntries entries keyed by a signed 3-D cell, held in a
// ring of cells that rotates one place per cycle while a request is scanned or
// written, past a single compare unit at its head. One request at a time: lookup,
// remove, region drop and the counts take one full rotation from transfer to
// result; add takes one rotation to find the match or lowest free entry and a
// second to write it (no write rotation when full, none at all when the kind is
// none); clear and an unused code take no rotation.
// Reset and clear free every entry at once; no clearing pass is needed.
module keyed_record_table #(
  parameter int unsigned TableEntries = krt_pkg::TableEntriesDef,
  parameter int unsigned RegionShift  = krt_pkg::RegionShiftDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  krt_req_if.sink   req_i,
  krt_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam logic [IdxW-1:0] LastPos = IdxW'(TableEntries - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_FINISH
  } state_e;

  state_e                                state_q, state_d;
  krt_pkg::req_e                         op_q, op_d;
  logic signed [krt_pkg::CoordW-1:0]     key_x_q, key_x_d, key_y_q, key_y_d;
  logic signed [krt_pkg::CoordW-1:0]     key_z_q, key_z_d;
  logic [krt_pkg::KindW-1:0]             new_kind_q, new_kind_d;
  logic signed [krt_pkg::RegionW-1:0]    region_x_q, region_x_d;
  logic signed [krt_pkg::RegionW-1:0]    region_z_q, region_z_d;
  logic [IdxW-1:0]                       pos_q, pos_d;
  logic                                  found_q, found_d, free_found_q, free_found_d;
  logic [IdxW-1:0]                       hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [krt_pkg::KindW-1:0]             hit_kind_q, hit_kind_d;
  logic [CntW-1:0]                       count_q, count_d;
  krt_pkg::status_e                      add_status_q, add_status_d;

  logic                                  rsp_valid_q, rsp_valid_d;
  logic [krt_pkg::StatusW-1:0]           rsp_status_q, rsp_status_d;
  logic [krt_pkg::IndexW-1:0]            rsp_index_q, rsp_index_d;
  logic [krt_pkg::KindW-1:0]             rsp_kind_q, rsp_kind_d;
  logic [krt_pkg::CountW-1:0]            rsp_count_q, rsp_count_d;

  krt_pkg::entry_t chain [TableEntries];
  krt_pkg::entry_t head, wb;
  krt_pkg::scan_t  flags;
  logic            shift, clear_all, last;
  logic [31:0]     idx_ext, cnt_ext;

  assign head      = chain[0];
  assign shift     = (state_q == S_SCAN) || (state_q == S_WRITE);
  assign last      = (pos_q == LastPos);
  assign req_i.ready = (state_q == S_IDLE);
  assign clear_all = req_i.valid && (state_q == S_IDLE) &&
                     (krt_pkg::req_e'(req_i.req_type) == krt_pkg::REQ_CLEAR);

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    krt_pkg::entry_t cell_in;
    if (g == TableEntries - 1) begin : g_tail
      assign cell_in = wb;
    end else begin : g_mid
      assign cell_in = chain[g+1];
    end
    krt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .clear_i (clear_all),
      .entry_i (cell_in),
      .entry_o (chain[g])
    );
  end

  krt_head #(
    .RegionShift (RegionShift)
  ) u_head (
    .entry_i    (head),
    .key_x_i    (key_x_q),
    .key_y_i    (key_y_q),
    .key_z_i    (key_z_q),
    .region_x_i (region_x_q),
    .region_z_i (region_z_q),
    .flags_o    (flags)
  );

  assign idx_ext = 32'(hit_idx_q);
  assign cnt_ext = 32'(count_q);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_x_d      = key_x_q;
    key_y_d      = key_y_q;
    key_z_d      = key_z_q;
    new_kind_d   = new_kind_q;
    region_x_d   = region_x_q;
    region_z_d   = region_z_q;
    pos_d        = pos_q;
    found_d      = found_q;
    free_found_d = free_found_q;
    hit_idx_d    = hit_idx_q;
    free_idx_d   = free_idx_q;
    hit_kind_d   = hit_kind_q;
    count_d      = count_q;
    add_status_d = add_status_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_index_d  = rsp_index_q;
    rsp_kind_d   = rsp_kind_q;
    rsp_count_d  = rsp_count_q;
    wb           = head;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d         = krt_pkg::req_e'(req_i.req_type);
          key_x_d      = req_i.cell_x;
          key_y_d      = req_i.cell_y;
          key_z_d      = req_i.cell_z;
          new_kind_d   = req_i.new_kind;
          region_x_d   = req_i.region_x;
          region_z_d   = req_i.region_z;
          pos_d        = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          hit_idx_d    = '0;
          free_idx_d   = '0;
          hit_kind_d   = krt_pkg::KindNone;
          count_d      = '0;
          add_status_d = krt_pkg::ST_OK;
          case (krt_pkg::req_e'(req_i.req_type))
            krt_pkg::REQ_ADD: begin
              if (req_i.new_kind == krt_pkg::KindNone) begin
                add_status_d = krt_pkg::ST_REJECTED;
                state_d      = S_FINISH;
              end else begin
                state_d = S_SCAN;
              end
            end
            krt_pkg::REQ_LOOKUP, krt_pkg::REQ_REMOVE, krt_pkg::REQ_DROP_REGION,
            krt_pkg::REQ_COUNT_ALL, krt_pkg::REQ_COUNT_REGION: begin
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (flags.key_hit && !found_q) begin
          found_d    = 1'b1;
          hit_idx_d  = pos_q;
          hit_kind_d = head.kind;
          // Free only the first match on remove.
          if (op_q == krt_pkg::REQ_REMOVE) begin
            wb.kind = krt_pkg::KindNone;
          end
        end
        if (!flags.live && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = pos_q;
        end
        case (op_q)
          krt_pkg::REQ_COUNT_ALL: begin
            if (flags.live) begin
              count_d = count_q + CntW'(1);
            end
          end
          krt_pkg::REQ_COUNT_REGION: begin
            if (flags.region_hit) begin
              count_d = count_q + CntW'(1);
            end
          end
          krt_pkg::REQ_DROP_REGION: begin
            if (flags.region_hit) begin
              count_d = count_q + CntW'(1);
              wb.kind = krt_pkg::KindNone;
            end
          end
          default: begin
          end
        endcase
        pos_d = last ? '0 : pos_q + IdxW'(1);
        if (last) begin
          state_d = S_FINISH;
          if (op_q == krt_pkg::REQ_ADD) begin
            if (found_d) begin
              state_d = S_WRITE;
            end else if (free_found_d) begin
              hit_idx_d = free_idx_d;
              state_d   = S_WRITE;
            end else begin
              add_status_d = krt_pkg::ST_FULL;
            end
          end
        end
      end

      S_WRITE: begin
        if (pos_q == hit_idx_q) begin
          wb = '{x: key_x_q, y: key_y_q, z: key_z_q, kind: new_kind_q};
        end
        pos_d = last ? '0 : pos_q + IdxW'(1);
        if (last) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        // Hold the result until the output register is free.
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = krt_pkg::ST_OK;
          rsp_index_d  = '0;
          rsp_kind_d   = krt_pkg::KindNone;
          rsp_count_d  = '0;
          case (op_q)
            krt_pkg::REQ_LOOKUP: begin
              if (found_q) begin
                rsp_index_d = idx_ext[krt_pkg::IndexW-1:0];
                rsp_kind_d  = hit_kind_q;
              end else begin
                rsp_status_d = krt_pkg::ST_NOT_FOUND;
              end
            end
            krt_pkg::REQ_ADD: begin
              rsp_status_d = add_status_q;
              if (add_status_q == krt_pkg::ST_OK) begin
                rsp_index_d = idx_ext[krt_pkg::IndexW-1:0];
                rsp_kind_d  = new_kind_q;
              end
            end
            krt_pkg::REQ_REMOVE: begin
              if (found_q) begin
                rsp_index_d = idx_ext[krt_pkg::IndexW-1:0];
              end else begin
                rsp_status_d = krt_pkg::ST_NOT_FOUND;
              end
            end
            krt_pkg::REQ_DROP_REGION, krt_pkg::REQ_COUNT_ALL,
            krt_pkg::REQ_COUNT_REGION: begin
              rsp_count_d = cnt_ext[krt_pkg::CountW-1:0];
            end
            krt_pkg::REQ_CLEAR: begin
              rsp_status_d = krt_pkg::ST_OK;
            end
            default: begin
              rsp_status_d = krt_pkg::ST_NOT_FOUND;
            end
          endcase
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= krt_pkg::REQ_LOOKUP;
      key_x_q      <= '0;
      key_y_q      <= '0;
      key_z_q      <= '0;
      new_kind_q   <= krt_pkg::KindNone;
      region_x_q   <= '0;
      region_z_q   <= '0;
      pos_q        <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      hit_idx_q    <= '0;
      free_idx_q   <= '0;
      hit_kind_q   <= krt_pkg::KindNone;
      count_q      <= '0;
      add_status_q <= krt_pkg::ST_OK;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= '0;
      rsp_index_q  <= '0;
      rsp_kind_q   <= '0;
      rsp_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      key_x_q      <= key_x_d;
      key_y_q      <= key_y_d;
      key_z_q      <= key_z_d;
      new_kind_q   <= new_kind_d;
      region_x_q   <= region_x_d;
      region_z_q   <= region_z_d;
      pos_q        <= pos_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      hit_idx_q    <= hit_idx_d;
      free_idx_q   <= free_idx_d;
      hit_kind_q   <= hit_kind_d;
      count_q      <= count_d;
      add_status_q <= add_status_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_status_q <= rsp_status_d;
      rsp_index_q  <= rsp_index_d;
      rsp_kind_q   <= rsp_kind_d;
      rsp_count_q  <= rsp_count_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.entry_index = rsp_index_q;
  assign rsp_o.entry_kind  = rsp_kind_q;
  assign rsp_o.live_count  = rsp_count_q;

endmodule
